### src/mcht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_pkg
// Shared types for the monotone convex hull trick unit: opcodes, result
// status codes, read address selects and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package mcht_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_INC    = 2'd2,
    OP_DEC    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // which envelope position the store read port points at
  typedef enum logic [2:0] {
    AS_FRONT,
    AS_FRONT1,
    AS_BACK,
    AS_BACK2,
    AS_MID,
    AS_MID1,
    AS_R
  } addr_sel_e;

  typedef struct packed {
    logic      ld_in;
    addr_sel_e addr_sel;
    logic      ld_l0;
    logic      ld_l1;
    logic      ld_p;
    logic      mul_red;
    logic      dir_back;
    logic      ld_e;
    logic      deq_front;
    logic      deq_back;
    logic      push_front;
    logic      push_back;
    logic      srch_init;
    logic      srch_lo;
    logic      srch_r;
    logic      ld_out;
    status_e   out_status;
    logic      out_eval;
  } cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    cnt_zero;
    logic    cnt_ge2;
    logic    full;
    logic    srch_more;
    logic    slope_le;
    logic    slope_eq;
    logic    icpt_le;
    logic    ge_red;
    logic    ge_eval;
    logic    out_free;
  } stat_t;

endpackage

### src/mcht_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_dp
// Datapath: line store, head and count, line registers, two shared
// multipliers, evaluation adders, search bounds and the result register.
// ----------------------------------------------------------------------------
module mcht_dp import mcht_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cmd_t                           cmd_i,
  output stat_t                          stat_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic [1:0]                     opcode_i,
  input  logic signed [COORD_WIDTH-1:0]  slope_i,
  input  logic signed [COORD_WIDTH-1:0]  intercept_i,
  input  logic signed [COORD_WIDTH-1:0]  x_coord_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [63:0]             value_o,
  output logic [1:0]                     status_o,
  output logic [$clog2(DEPTH+1)-1:0]     line_count_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH+1);
  localparam int SUMW = CW + 1;
  localparam int SW   = COORD_WIDTH + 1;
  localparam int DW   = COORD_WIDTH + 2;
  localparam int PW   = 2 * DW;
  localparam int LW   = 2 * SW;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CW-1:0] k);
    logic [SUMW-1:0] s;
    s = SUMW'(head) + SUMW'(k);
    if (s >= SUMW'(DEPTH)) begin
      s = s - SUMW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic                   mode_q;
  opcode_e                op_q;
  logic signed [SW-1:0]   na_q, nb_q;
  logic signed [COORD_WIDTH-1:0] x_q;
  logic [AW-1:0]          head_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          lo_q, r_q;
  logic [LW-1:0]          mem [DEPTH];
  logic [LW-1:0]          rdata_q;
  logic signed [SW-1:0]   l0a_q, l0b_q, l1a_q, l1b_q;
  logic signed [PW-1:0]   pr0_q, pr1_q, e0_q, e1_q;
  logic                   out_valid_q;
  logic signed [63:0]     value_q;
  status_e                status_q;
  logic [CW-1:0]          lcount_q;

  logic signed [SW-1:0]   sa, sb;
  logic [SUMW-1:0]        mid_sum;
  logic [CW-1:0]          mid;
  logic [CW-1:0]          rd_k;
  logic [AW-1:0]          rd_addr, wr_addr, head_dec;
  logic signed [SW-1:0]   pa, pb, qa, qb, ra, rb;
  logic signed [DW-1:0]   op0a, op0b, op1a, op1b;
  logic signed [63:0]     eval64;

  // entry negation in maximum mode
  assign sa = mode_q ? -SW'(slope_i)     : SW'(slope_i);
  assign sb = mode_q ? -SW'(intercept_i) : SW'(intercept_i);

  assign mid_sum = SUMW'(lo_q) + SUMW'(r_q) - SUMW'(1);
  assign mid     = mid_sum[CW:1];

  always_comb begin
    case (cmd_i.addr_sel)
      AS_FRONT:  rd_k = '0;
      AS_FRONT1: rd_k = CW'(1);
      AS_BACK:   rd_k = count_q - CW'(1);
      AS_BACK2:  rd_k = count_q - CW'(2);
      AS_MID:    rd_k = mid;
      AS_MID1:   rd_k = mid + CW'(1);
      AS_R:      rd_k = r_q;
      default:   rd_k = '0;
    endcase
  end

  assign rd_addr  = slot(head_q, rd_k);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign wr_addr  = cmd_i.push_front ? head_dec : slot(head_q, count_q);

  // line roles for the redundancy test: middle line q between p and r
  always_comb begin
    if (cmd_i.dir_back) begin
      pa = l0a_q; pb = l0b_q;
      qa = l1a_q; qb = l1b_q;
      ra = na_q;  rb = nb_q;
    end else begin
      pa = na_q;  pb = nb_q;
      qa = l0a_q; qb = l0b_q;
      ra = l1a_q; rb = l1b_q;
    end
    if (cmd_i.mul_red) begin
      op0a = DW'(qb) - DW'(pb);
      op0b = DW'(qa) - DW'(ra);
      op1a = DW'(rb) - DW'(qb);
      op1b = DW'(pa) - DW'(qa);
    end else begin
      op0a = DW'(l0a_q);
      op0b = DW'(x_q);
      op1a = DW'(l1a_q);
      op1b = DW'(x_q);
    end
  end

  assign eval64 = 64'(e0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.deq_front) begin
        head_q  <= slot(head_q, CW'(1));
        count_q <= count_q - CW'(1);
      end else if (cmd_i.deq_back) begin
        count_q <= count_q - CW'(1);
      end else if (cmd_i.push_front) begin
        head_q  <= head_dec;
        count_q <= count_q + CW'(1);
      end else if (cmd_i.push_back) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_front || cmd_i.push_back) begin
      mem[wr_addr] <= {na_q, nb_q};
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q <= opcode_e'(opcode_i);
      na_q <= sa;
      nb_q <= sb;
      x_q  <= x_coord_i;
    end
    if (cmd_i.ld_l0) begin
      l0a_q <= rdata_q[LW-1:SW];
      l0b_q <= rdata_q[SW-1:0];
    end
    if (cmd_i.ld_l1) begin
      l1a_q <= rdata_q[LW-1:SW];
      l1b_q <= rdata_q[SW-1:0];
    end
    if (cmd_i.ld_p) begin
      pr0_q <= op0a * op0b;
      pr1_q <= op1a * op1b;
    end
    if (cmd_i.ld_e) begin
      e0_q <= pr0_q + PW'(l0b_q);
      e1_q <= pr1_q + PW'(l1b_q);
    end
    if (cmd_i.srch_init) begin
      lo_q <= '0;
      r_q  <= count_q - CW'(1);
    end else if (cmd_i.srch_lo) begin
      lo_q <= mid + CW'(1);
    end else if (cmd_i.srch_r) begin
      r_q <= mid;
    end
    if (cmd_i.ld_out) begin
      status_q <= cmd_i.out_status;
      lcount_q <= count_q;
      if (cmd_i.out_eval) begin
        value_q <= mode_q ? -eval64 : eval64;
      end else begin
        value_q <= '0;
      end
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.cnt_zero  = (count_q == '0);
  assign stat_o.cnt_ge2   = (count_q >= CW'(2));
  assign stat_o.full      = (count_q >= CW'(DEPTH));
  assign stat_o.srch_more = (r_q > lo_q);
  assign stat_o.slope_le  = (l0a_q <= na_q);
  assign stat_o.slope_eq  = (l0a_q == na_q);
  assign stat_o.icpt_le   = (l0b_q <= nb_q);
  assign stat_o.ge_red    = (pr0_q >= pr1_q);
  assign stat_o.ge_eval   = (e0_q >= e1_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign status_o     = status_q;
  assign line_count_o = lcount_q;

endmodule

### src/mcht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_ctrl
// Sequencer: steps adds, pops, binary search and the final evaluation
// through the datapath one store read per cycle.
// ----------------------------------------------------------------------------
module mcht_ctrl import mcht_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_AF_RD, S_AF_LD, S_AF_CHK,
    S_AB_RD, S_AB_LD, S_AB_CHK,
    S_LCHK, S_LA, S_LB, S_LC, S_LM, S_LE, S_LD,
    S_INS,
    S_FA, S_FB, S_FM, S_FE,
    S_RESULT
  } state_e;

  typedef enum logic [2:0] {
    K_RED_F, K_RED_B, K_EV_F, K_EV_B, K_EV_M
  } kind_e;

  state_e  state_q;
  kind_e   kind_q;
  status_e res_status_q;
  logic    res_eval_q;
  logic    is_red;

  assign is_red = (kind_q == K_RED_F) || (kind_q == K_RED_B);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= K_RED_F;
      res_status_q <= ST_OK;
      res_eval_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_eval_q <= 1'b0;
          if (stat_i.op == OP_ADD) begin
            if (stat_i.cnt_zero) begin
              res_status_q <= ST_OK;
              state_q      <= S_RESULT;
            end else begin
              state_q <= S_AF_RD;
            end
          end else if (stat_i.cnt_zero) begin
            res_status_q <= ST_EMPTY;
            state_q      <= S_RESULT;
          end else begin
            case (stat_i.op)
              OP_SEARCH: kind_q <= K_EV_M;
              OP_INC:    kind_q <= K_EV_F;
              default:   kind_q <= K_EV_B;
            endcase
            state_q <= S_LCHK;
          end
        end
        S_AF_RD: state_q <= S_AF_LD;
        S_AF_LD: state_q <= S_AF_CHK;
        S_AF_CHK: begin
          if (stat_i.slope_le) begin
            kind_q <= K_RED_F;
            if (stat_i.slope_eq && stat_i.icpt_le) begin
              res_status_q <= ST_OK;
              state_q      <= S_RESULT;
            end else begin
              state_q <= S_LCHK;
            end
          end else begin
            state_q <= S_AB_RD;
          end
        end
        S_AB_RD: state_q <= S_AB_LD;
        S_AB_LD: state_q <= S_AB_CHK;
        S_AB_CHK: begin
          kind_q <= K_RED_B;
          if (stat_i.slope_eq && stat_i.icpt_le) begin
            res_status_q <= ST_OK;
            state_q      <= S_RESULT;
          end else begin
            state_q <= S_LCHK;
          end
        end
        S_LCHK: begin
          if (kind_q == K_EV_M) begin
            state_q <= stat_i.srch_more ? S_LA : S_FA;
          end else if (stat_i.cnt_ge2) begin
            state_q <= S_LA;
          end else begin
            state_q <= is_red ? S_INS : S_FA;
          end
        end
        S_LA: state_q <= S_LB;
        S_LB: state_q <= S_LC;
        S_LC: state_q <= S_LM;
        S_LM: state_q <= is_red ? S_LD : S_LE;
        S_LE: state_q <= S_LD;
        S_LD: begin
          case (kind_q)
            K_RED_F, K_RED_B: state_q <= stat_i.ge_red ? S_LCHK : S_INS;
            K_EV_F, K_EV_B:   state_q <= stat_i.ge_eval ? S_LCHK : S_FA;
            default:          state_q <= S_LCHK;
          endcase
        end
        S_INS: begin
          res_status_q <= stat_i.full ? ST_FULL : ST_OK;
          state_q      <= S_RESULT;
        end
        S_FA: state_q <= S_FB;
        S_FB: state_q <= S_FM;
        S_FM: state_q <= S_FE;
        S_FE: begin
          res_status_q <= ST_OK;
          res_eval_q   <= 1'b1;
          state_q      <= S_RESULT;
        end
        S_RESULT: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.addr_sel   = AS_FRONT;
    cmd_o.out_status = res_status_q;
    cmd_o.out_eval   = res_eval_q;
    cmd_o.mul_red    = is_red;
    cmd_o.dir_back   = (kind_q == K_RED_B);
    in_ready_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.ld_in = in_valid_i;
      end
      S_DISPATCH: begin
        if (stat_i.cnt_zero && stat_i.op == OP_ADD) begin
          cmd_o.push_back = 1'b1;
        end
        if (!stat_i.cnt_zero && stat_i.op == OP_SEARCH) begin
          cmd_o.srch_init = 1'b1;
        end
      end
      S_AF_RD:  cmd_o.addr_sel = AS_FRONT;
      S_AF_LD:  cmd_o.ld_l0 = 1'b1;
      S_AF_CHK: begin
        if (stat_i.slope_le && stat_i.slope_eq && !stat_i.icpt_le) begin
          cmd_o.deq_front = 1'b1;
        end
      end
      S_AB_RD:  cmd_o.addr_sel = AS_BACK;
      S_AB_LD:  cmd_o.ld_l0 = 1'b1;
      S_AB_CHK: begin
        if (stat_i.slope_eq && !stat_i.icpt_le) begin
          cmd_o.deq_back = 1'b1;
        end
      end
      S_LA: begin
        case (kind_q)
          K_RED_B: cmd_o.addr_sel = AS_BACK2;
          K_EV_B:  cmd_o.addr_sel = AS_BACK;
          K_EV_M:  cmd_o.addr_sel = AS_MID;
          default: cmd_o.addr_sel = AS_FRONT;
        endcase
      end
      S_LB: begin
        cmd_o.ld_l0 = 1'b1;
        case (kind_q)
          K_RED_B: cmd_o.addr_sel = AS_BACK;
          K_EV_B:  cmd_o.addr_sel = AS_BACK2;
          K_EV_M:  cmd_o.addr_sel = AS_MID1;
          default: cmd_o.addr_sel = AS_FRONT1;
        endcase
      end
      S_LC: cmd_o.ld_l1 = 1'b1;
      S_LM: cmd_o.ld_p  = 1'b1;
      S_LE: cmd_o.ld_e  = 1'b1;
      S_LD: begin
        case (kind_q)
          K_RED_F: cmd_o.deq_front = stat_i.ge_red;
          K_RED_B: cmd_o.deq_back  = stat_i.ge_red;
          K_EV_F:  cmd_o.deq_front = stat_i.ge_eval;
          K_EV_B:  cmd_o.deq_back  = stat_i.ge_eval;
          default: begin
            cmd_o.srch_lo = stat_i.ge_eval;
            cmd_o.srch_r  = !stat_i.ge_eval;
          end
        endcase
      end
      S_INS: begin
        if (!stat_i.full) begin
          cmd_o.push_front = (kind_q == K_RED_F);
          cmd_o.push_back  = (kind_q == K_RED_B);
        end
      end
      S_FA: begin
        case (kind_q)
          K_EV_B:  cmd_o.addr_sel = AS_BACK;
          K_EV_M:  cmd_o.addr_sel = AS_R;
          default: cmd_o.addr_sel = AS_FRONT;
        endcase
      end
      S_FB: cmd_o.ld_l0 = 1'b1;
      S_FM: begin
        cmd_o.ld_p    = 1'b1;
        cmd_o.mul_red = 1'b0;
      end
      S_FE:     cmd_o.ld_e   = 1'b1;
      S_RESULT: cmd_o.ld_out = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

### src/monotone_convex_hull_trick_unit.sv
`timescale 1ns / 1ps
// adds: into an empty store the line is pushed at once, else it goes in at the
// front or, after a check of the back line, at the back, popping redundant lines first;
// queries: an empty store gives an empty status, search halves its range and
// monotone queries pop lines that no longer win; one word in flight, the next taken
// in the cycle after the result loads; reset clears head, count, mode and the result
// valid flag; the line store is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// monotone_convex_hull_trick_unit
// Lower/upper envelope of lines in a circular deque with add, binary-search
// query and monotone front/back queries.
// ----------------------------------------------------------------------------
module monotone_convex_hull_trick_unit import mcht_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [COORD_WIDTH-1:0] slope_i,
  input  logic signed [COORD_WIDTH-1:0] intercept_i,
  input  logic signed [COORD_WIDTH-1:0] x_coord_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [63:0]            value_o,
  output logic [1:0]                    status_o,
  output logic [$clog2(DEPTH+1)-1:0]    line_count_o
);

  cmd_t  cmd;
  stat_t stat;

  mcht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mcht_dp #(
    .DEPTH       (DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .opcode_i     (opcode_i),
    .slope_i      (slope_i),
    .intercept_i  (intercept_i),
    .x_coord_i    (x_coord_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .value_o      (value_o),
    .status_o     (status_o),
    .line_count_o (line_count_o)
  );

endmodule

### tb/mcht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcht_checker
// Watches the word and result channels of the hull trick unit, keeps its own
// envelope store in step with every accepted word and compares each result
// word field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module mcht_checker import mcht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] slope_i,
  input  logic signed [31:0] intercept_i,
  input  logic signed [31:0] x_coord_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [63:0] value_i,
  input  logic [1:0]         status_i,
  input  logic [10:0]        line_count_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int Depth = 1024;

  typedef struct {
    logic signed [63:0] value;
    status_e            status;
    logic [10:0]        line_count;
  } hull_result_t;

  hull_result_t       result_q[$];
  logic signed [63:0] line_slope[Depth];
  logic signed [63:0] line_icpt[Depth];
  int                 head;
  int                 count;
  logic               max_mode;

  assign pending_o = result_q.size();

  function automatic int slot(int k);
    return (head + k) % Depth;
  endfunction

  function automatic logic signed [63:0] eval_line(int k, logic signed [63:0] x);
    return line_slope[slot(k)] * x + line_icpt[slot(k)];
  endfunction

  // middle line is never below both neighbours, exact wide compare
  function automatic bit is_redundant(logic signed [63:0] a1, logic signed [63:0] b1,
                                      logic signed [63:0] a2, logic signed [63:0] b2,
                                      logic signed [63:0] a3, logic signed [63:0] b3);
    logic signed [127:0] l0, l1, r0, r1;
    l0 = b2 - b1;
    l1 = a2 - a3;
    r0 = b3 - b2;
    r1 = a1 - a2;
    return (l0 * l1) >= (r0 * r1);
  endfunction

  function automatic hull_result_t envelope_step(opcode_e op, logic signed [63:0] a,
                                                 logic signed [63:0] b,
                                                 logic signed [63:0] x);
    hull_result_t r;
    bit           drop;
    int           lo, hi, mid;
    r.value  = '0;
    r.status = ST_OK;
    drop     = 0;
    if (op == OP_ADD) begin
      if (max_mode) begin
        a = -a;
        b = -b;
      end
      if (count == 0) begin
        line_slope[slot(0)] = a;
        line_icpt[slot(0)]  = b;
        count = 1;
      end else if (line_slope[slot(0)] <= a) begin
        if (line_slope[slot(0)] == a) begin
          if (line_icpt[slot(0)] <= b) drop = 1;
          else begin
            head = slot(1);
            count--;
          end
        end
        if (!drop) begin
          while (count >= 2 && is_redundant(a, b, line_slope[slot(0)], line_icpt[slot(0)],
                                            line_slope[slot(1)], line_icpt[slot(1)])) begin
            head = slot(1);
            count--;
          end
          if (count >= Depth) r.status = ST_FULL;
          else begin
            head = slot(Depth - 1);
            line_slope[head] = a;
            line_icpt[head]  = b;
            count++;
          end
        end
      end else begin
        if (line_slope[slot(count - 1)] == a) begin
          if (line_icpt[slot(count - 1)] <= b) drop = 1;
          else count--;
        end
        if (!drop) begin
          while (count >= 2 && is_redundant(line_slope[slot(count - 2)],
                                            line_icpt[slot(count - 2)],
                                            line_slope[slot(count - 1)],
                                            line_icpt[slot(count - 1)], a, b))
            count--;
          if (count >= Depth) r.status = ST_FULL;
          else begin
            line_slope[slot(count)] = a;
            line_icpt[slot(count)]  = b;
            count++;
          end
        end
      end
    end else if (count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      if (op == OP_SEARCH) begin
        lo = -1;
        hi = count - 1;
        while (hi - lo > 1) begin
          mid = (lo + hi) / 2;
          if (eval_line(mid, x) >= eval_line(mid + 1, x)) lo = mid;
          else hi = mid;
        end
        r.value = eval_line(hi, x);
      end else if (op == OP_INC) begin
        while (count >= 2 && eval_line(0, x) >= eval_line(1, x)) begin
          head = slot(1);
          count--;
        end
        r.value = eval_line(0, x);
      end else begin
        while (count >= 2 && eval_line(count - 1, x) >= eval_line(count - 2, x))
          count--;
        r.value = eval_line(count - 1, x);
      end
      if (max_mode) r.value = -r.value;
    end
    r.line_count = 11'(count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hull_result_t got, want;
    if (!rst_ni) begin
      head         = 0;
      count        = 0;
      max_mode     = 1'b0;
      fail_count_o <= 0;
      result_q.delete();
    end else begin
      if (cfg_we_i) max_mode = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result word with nothing expected: value %0d status %0d count %0d",
                   $time, value_i, status_i, line_count_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = result_q[0];
          result_q.delete(0);
          if (value_i !== want.value || status_i !== want.status ||
              line_count_i !== want.line_count) begin
            $display("%0t: mismatch expected value %0d status %0d count %0d, actual %0d %0d %0d",
                     $time, want.value, want.status, want.line_count,
                     value_i, status_i, line_count_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        got = envelope_step(opcode_e'(opcode_i), 64'(slope_i), 64'(intercept_i),
                            64'(x_coord_i));
        result_q.push_back(got);
      end
    end
  end

endmodule

### tb/tb_monotone_convex_hull_trick_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_monotone_convex_hull_trick_unit
// Drives adds and the three query kinds into the hull trick unit in both
// envelope modes, with bursty words and a stalling receiver; a checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_monotone_convex_hull_trick_unit import mcht_pkg::*;;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         opcode;
  logic signed [31:0] slope;
  logic signed [31:0] intercept;
  logic signed [31:0] x_coord;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] value;
  logic [1:0]         status;
  logic [10:0]        line_count;
  int                 fail_count;
  int                 pending;
  int                 stall_cnt;

  longint slope_back, slope_front, x_up, x_down;

  monotone_convex_hull_trick_unit #(.DEPTH(1024), .COORD_WIDTH(32)) u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .opcode_i(opcode),
    .slope_i(slope), .intercept_i(intercept), .x_coord_i(x_coord),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .value_o(value),
    .status_o(status), .line_count_o(line_count)
  );

  mcht_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .opcode_i(opcode),
    .slope_i(slope), .intercept_i(intercept), .x_coord_i(x_coord),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .value_i(value),
    .status_i(status), .line_count_i(line_count),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // receiver: long fully-ready stretches, otherwise random stalls
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt[7:6] == 2'd1) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) < 60);
    end
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // called at a rising edge; once the word is taken it may drop valid and idle before returning
  task automatic send_word(opcode_e op, longint a, longint b, longint x);
    in_valid  <= 1'b1;
    opcode    <= op;
    slope     <= a[31:0];
    intercept <= b[31:0];
    x_coord   <= x[31:0];
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if ($urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic longint rand_full();
    return longint'($signed($urandom()));
  endfunction

  task automatic random_word();
    int     pick;
    longint b;
    pick = $urandom_range(0, 99);
    b = ($urandom_range(0, 3) == 0) ? rand_full() : longint'($urandom_range(0, 2000)) - 1000;
    if (pick < 35) begin
      slope_back -= $urandom_range(0, 40);
      if (slope_back < -2147483648) slope_back = -longint'($urandom_range(0, 1000));
      send_word(OP_ADD, slope_back, b, rand_full());
    end else if (pick < 45) begin
      slope_front += $urandom_range(0, 40);
      if (slope_front > 2147483647) slope_front = $urandom_range(0, 1000);
      send_word(OP_ADD, slope_front, b, rand_full());
    end else if (pick < 52) begin
      send_word(OP_ADD, rand_full(), rand_full(), rand_full());
    end else if (pick < 67) begin
      send_word(OP_SEARCH, rand_full(), rand_full(),
                ($urandom_range(0, 1) != 0) ? rand_full()
                                            : longint'($urandom_range(0, 400)) - 200);
    end else if (pick < 80) begin
      x_up += $urandom_range(0, 30);
      if (x_up > 2147483647) x_up = -2000;
      send_word(OP_INC, rand_full(), rand_full(), x_up);
    end else if (pick < 93) begin
      x_down -= $urandom_range(0, 30);
      if (x_down < -2147483648) x_down = 2000;
      send_word(OP_DEC, rand_full(), rand_full(), x_down);
    end else begin
      send_word(opcode_e'($urandom_range(1, 3)), rand_full(), rand_full(), rand_full());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    opcode    = OP_ADD;
    slope     = '0;
    intercept = '0;
    x_coord   = '0;
    slope_back  = 0;
    slope_front = 0;
    x_up        = -2000;
    x_down      = 2000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(1'b0);

    // queries on an empty store
    send_word(OP_SEARCH, 0, 0, 5);
    send_word(OP_INC, 0, 0, -2147483648);
    send_word(OP_DEC, 0, 0, 2147483647);
    // extreme slopes and intercepts, equal-slope drop and replace
    send_word(OP_ADD, 2147483647, 2147483647, 0);
    send_word(OP_ADD, 2147483647, 2147483647, 0);
    send_word(OP_ADD, 2147483647, -2147483648, 0);
    send_word(OP_ADD, 0, 100, 0);
    send_word(OP_ADD, -2147483648, 2147483647, 0);
    send_word(OP_ADD, -2147483648, -2147483648, 0);
    send_word(OP_SEARCH, 0, 0, -2147483648);
    send_word(OP_SEARCH, 0, 0, 2147483647);
    send_word(OP_SEARCH, 0, 0, 0);
    send_word(OP_DEC, 0, 0, 2147483647);
    send_word(OP_INC, 0, 0, -2147483648);
    send_word(OP_INC, 0, 0, 2147483647);
    drain();

    // a long run of lines that all stay on the envelope, then deep queries
    for (int k = 2000; k < 2100; k++) send_word(OP_ADD, -k, longint'(k) * k, 0);
    send_word(OP_SEARCH, 0, 0, 4101);
    send_word(OP_DEC, 0, 0, 4050);
    send_word(OP_INC, 0, 0, 2147483647);
    drain();

    // mode changed with lines still held, then the random phases
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0] ^ 1'b1);
      for (int n = 0; n < 155; n++) random_word();
      drain();
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
src/mcht_pkg.sv
src/mcht_dp.sv
src/mcht_ctrl.sv
src/monotone_convex_hull_trick_unit.sv
tb/mcht_checker.sv
tb/tb_monotone_convex_hull_trick_unit.sv
